// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DLFP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DLFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define DLFP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/dlfp_pkg.sv -----
package dlfp_pkg;

    localparam int VALUE_BITS      = 32;
    localparam int FRAC_BITS       = 16;
    localparam int MAX_FRAC_DIGITS = 9;

    localparam int CHAR_W      = 8;
    localparam int OUT_VALUE_W = 32;
    localparam int STATUS_W    = 3;

    function automatic longint unsigned pow10(input int n);
        longint unsigned p;
        p = 64'd1;
        for (int i = 0; i < n; i++) begin
            p = p * 64'd10;
        end
        return p;
    endfunction

    localparam longint unsigned INT_LIMIT =
        (VALUE_BITS - 1 > FRAC_BITS) ? (64'd1 << (VALUE_BITS - 1 - FRAC_BITS)) : 64'd0;

    localparam int INT_W  = $clog2(INT_LIMIT + 2);
    localparam int DEN_W  = $clog2(pow10(MAX_FRAC_DIGITS) + 1);
    localparam int CNT_W  = $clog2(MAX_FRAC_DIGITS + 1);
    localparam int MAG_W  = VALUE_BITS + 1;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int STEP_W = $clog2(FRAC_BITS + 2);

    localparam logic [VALUE_BITS-1:0] MOST_NEG = {1'b1, {(VALUE_BITS - 1){1'b0}}};
    localparam logic [VALUE_BITS-1:0] MOST_POS = ~MOST_NEG;

    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] SEP_RESET  = 8'd44;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK          = 3'd0,
        STAT_BAD_CHAR    = 3'd1,
        STAT_MULTI_POINT = 3'd2,
        STAT_TRAIL_POINT = 3'd3,
        STAT_SATURATED   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_PARSE,
        FSM_CHECK,
        FSM_DIVIDE,
        FSM_ROUND
    } fsm_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- design/dlfp_frac_div.sv -----
module dlfp_frac_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [dlfp_pkg::DEN_W-1:0]    dividend,
    input  logic [dlfp_pkg::DEN_W-1:0]    divisor,
    input  logic                          round_en,
    output dlfp_pkg::div_stat_t           stat,
    output logic [dlfp_pkg::Q_W-1:0]      quotient
);
    import dlfp_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [Q_W-1:0]    q_reg, q_next;
    logic              round_reg, round_next;

    logic [DEN_W:0]    rem_shift;
    logic [DEN_W:0]    rem_sub;
    logic              ge;

    // One restoring step per cycle; the same compare also gives the rounding bit.
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_sub   = rem_shift - {1'b0, den_reg};
    assign ge        = rem_shift >= {1'b0, den_reg};

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        step_next  = step_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        q_next     = q_reg;
        round_next = round_reg;
        if (start) begin
            busy_next  = (FRAC_BITS != 0);
            done_next  = (FRAC_BITS == 0);
            step_next  = '0;
            rem_next   = dividend;
            den_next   = divisor;
            q_next     = '0;
            round_next = round_en;
        end else if (busy_reg) begin
            rem_next  = ge ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            q_next    = Q_W'({q_reg, ge});
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(FRAC_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        q_reg     <= q_next;
        round_reg <= round_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg + Q_W'(round_reg && ge);

endmodule

// ----- design/decimal_list_to_fixed_point.sv -----
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_char_code, s_end_of_string
// m_        out        m_valid/m_ready    m_value, m_status, m_last_of_string
// cfg_      in         cfg_valid/cfg_ready cfg_separator_char
//
// A character that does not end a field is accepted in IDLE, then decoded in PARSE.
// A field end adds the CHECK state, the DIVIDE state in the restoring divider
// (one quotient bit per cycle) and the ROUND state.
// Reset sets the separator to a comma, clears all field state and drops any result.
// A result waits in the output register; the next character is still taken, and a
// later result stalls in its state until the register is free.
module decimal_list_to_fixed_point (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [dlfp_pkg::CHAR_W-1:0]         s_char_code,
    input  logic                                s_end_of_string,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [dlfp_pkg::OUT_VALUE_W-1:0]    m_value,
    output logic [dlfp_pkg::STATUS_W-1:0]       m_status,
    output logic                                m_last_of_string,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dlfp_pkg::CHAR_W-1:0]         cfg_separator_char
);
    import dlfp_pkg::*;

    fsm_t state_reg, state_next;

    logic [CHAR_W-1:0] sep_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              eos_reg;

    logic              neg_reg, neg_next;
    logic [INT_W-1:0]  int_reg, int_next;
    logic [DEN_W-1:0]  frac_reg, frac_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [CNT_W-1:0]  fcnt_reg, fcnt_next;
    logic              point_reg, point_next;
    logic              start_reg, start_next;
    logic              skip_reg, skip_next;

    logic                   m_valid_reg, m_valid_next;
    logic [OUT_VALUE_W-1:0] m_value_reg;
    status_t                m_status_reg;
    logic                   m_last_reg;

    logic                   take_char;
    logic                   load_out;
    logic [OUT_VALUE_W-1:0] out_value_c;
    status_t                out_status_c;
    logic                   clear_fld;
    logic                   update_fld;
    logic                   skip_we;
    logic                   skip_d;
    logic                   div_start;
    logic                   slot_free;

    logic                   is_sep, is_sign, is_point, is_digit;
    logic [3:0]             digit;
    status_t                parse_err;
    logic                   chk_trail, chk_ovf;

    logic [INT_W+3:0]       int_mul;
    logic [DEN_W+3:0]       frac_mul;
    logic [DEN_W+3:0]       den_mul;

    div_stat_t              div_stat;
    logic [Q_W-1:0]         quotient;
    logic [MAG_W-1:0]       mag;
    logic [MAG_W-1:0]       mag_max;
    logic                   mag_sat;
    logic [VALUE_BITS-1:0]  signed_val;
    logic [VALUE_BITS-1:0]  sat_val;

    assign slot_free = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;

    assign is_sep   = char_reg == sep_reg;
    assign is_sign  = (char_reg == CHAR_PLUS || char_reg == CHAR_MINUS) && start_reg;
    assign is_point = char_reg == CHAR_POINT;
    assign is_digit = char_reg >= CHAR_ZERO && char_reg <= CHAR_NINE;
    assign digit    = char_reg[3:0];

    always_comb begin
        parse_err = STAT_OK;
        if (is_point && point_reg) begin
            parse_err = STAT_MULTI_POINT;
        end else if (!is_sign && !is_point && !is_digit) begin
            parse_err = STAT_BAD_CHAR;
        end
    end

    assign chk_trail = point_reg && fcnt_reg == '0;
    assign chk_ovf   = int_reg > INT_W'(INT_LIMIT);

    assign int_mul  = (INT_W + 4)'(int_reg) * 4'd10 + (INT_W + 4)'(digit);
    assign frac_mul = (DEN_W + 4)'(frac_reg) * 4'd10 + (DEN_W + 4)'(digit);
    assign den_mul  = (DEN_W + 4)'(den_reg) * 4'd10;

    dlfp_frac_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (frac_reg),
        .divisor  (den_reg),
        .round_en (fcnt_reg != '0),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign mag        = (MAG_W'(int_reg) << FRAC_BITS) + MAG_W'(quotient);
    assign mag_max    = neg_reg ? MAG_W'(MOST_NEG) : MAG_W'(MOST_NEG) - MAG_W'(1);
    assign mag_sat    = mag > mag_max;
    assign signed_val = neg_reg ? (VALUE_BITS'(0) - mag[VALUE_BITS-1:0]) : mag[VALUE_BITS-1:0];
    assign sat_val    = neg_reg ? MOST_NEG : MOST_POS;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE: begin
                if (s_valid) begin
                    state_next = FSM_PARSE;
                end
            end
            FSM_PARSE: begin
                if (skip_reg) begin
                    state_next = FSM_IDLE;
                end else if (is_sep) begin
                    state_next = FSM_CHECK;
                end else if (parse_err != STAT_OK) begin
                    state_next = slot_free ? FSM_IDLE : FSM_PARSE;
                end else begin
                    state_next = eos_reg ? FSM_CHECK : FSM_IDLE;
                end
            end
            FSM_CHECK: begin
                if (chk_trail || chk_ovf) begin
                    state_next = slot_free ? FSM_IDLE : FSM_CHECK;
                end else begin
                    state_next = FSM_DIVIDE;
                end
            end
            FSM_DIVIDE: begin
                if (div_stat.done) begin
                    state_next = FSM_ROUND;
                end
            end
            FSM_ROUND: begin
                if (slot_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_comb begin
        take_char    = 1'b0;
        load_out     = 1'b0;
        out_value_c  = '0;
        out_status_c = STAT_OK;
        clear_fld    = 1'b0;
        update_fld   = 1'b0;
        skip_we      = 1'b0;
        skip_d       = 1'b0;
        div_start    = 1'b0;
        case (state_reg)
            FSM_IDLE: begin
                take_char = 1'b1;
            end
            FSM_PARSE: begin
                if (skip_reg) begin
                    if (eos_reg) begin
                        clear_fld = 1'b1;
                        skip_we   = 1'b1;
                    end
                end else if (is_sep) begin
                    update_fld = 1'b0;
                end else if (parse_err != STAT_OK) begin
                    if (slot_free) begin
                        load_out     = 1'b1;
                        out_status_c = parse_err;
                        clear_fld    = 1'b1;
                        skip_we      = 1'b1;
                        skip_d       = !eos_reg;
                    end
                end else begin
                    update_fld = 1'b1;
                end
            end
            FSM_CHECK: begin
                if (chk_trail || chk_ovf) begin
                    if (slot_free) begin
                        load_out     = 1'b1;
                        out_status_c = chk_trail ? STAT_TRAIL_POINT : STAT_SATURATED;
                        out_value_c  = chk_trail ? '0 : OUT_VALUE_W'(signed'(sat_val));
                        clear_fld    = 1'b1;
                        skip_we      = 1'b1;
                        skip_d       = !eos_reg;
                    end
                end else begin
                    div_start = 1'b1;
                end
            end
            FSM_DIVIDE: begin
                div_start = 1'b0;
            end
            FSM_ROUND: begin
                if (slot_free) begin
                    load_out     = 1'b1;
                    out_status_c = mag_sat ? STAT_SATURATED : STAT_OK;
                    out_value_c  = mag_sat ? OUT_VALUE_W'(signed'(sat_val))
                                           : OUT_VALUE_W'(signed'(signed_val));
                    clear_fld    = 1'b1;
                    skip_we      = 1'b1;
                    skip_d       = mag_sat && !eos_reg;
                end
            end
            default: begin
                take_char = 1'b0;
            end
        endcase
    end

    always_comb begin
        neg_next   = neg_reg;
        int_next   = int_reg;
        frac_next  = frac_reg;
        den_next   = den_reg;
        fcnt_next  = fcnt_reg;
        point_next = point_reg;
        start_next = start_reg;
        skip_next  = skip_we ? skip_d : skip_reg;
        if (clear_fld) begin
            neg_next   = 1'b0;
            int_next   = '0;
            frac_next  = '0;
            den_next   = DEN_W'(1);
            fcnt_next  = '0;
            point_next = 1'b0;
            start_next = 1'b1;
        end else if (update_fld) begin
            start_next = 1'b0;
            if (is_sign) begin
                neg_next = char_reg == CHAR_MINUS;
            end else if (is_point) begin
                point_next = 1'b1;
            end else if (point_reg) begin
                if (fcnt_reg < CNT_W'(MAX_FRAC_DIGITS)) begin
                    frac_next = frac_mul[DEN_W-1:0];
                    den_next  = den_mul[DEN_W-1:0];
                    fcnt_next = fcnt_reg + CNT_W'(1);
                end
            end else if (!chk_ovf) begin
                if (int_mul > (INT_W + 4)'(INT_LIMIT)) begin
                    int_next = INT_W'(INT_LIMIT + 1);
                end else begin
                    int_next = int_mul[INT_W-1:0];
                end
            end
        end
    end

    assign m_valid_next = load_out ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            sep_reg     <= SEP_RESET;
            neg_reg     <= 1'b0;
            int_reg     <= '0;
            frac_reg    <= '0;
            den_reg     <= DEN_W'(1);
            fcnt_reg    <= '0;
            point_reg   <= 1'b0;
            start_reg   <= 1'b1;
            skip_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            if (cfg_valid) begin
                sep_reg <= cfg_separator_char;
            end
            neg_reg     <= neg_next;
            int_reg     <= int_next;
            frac_reg    <= frac_next;
            den_reg     <= den_next;
            fcnt_reg    <= fcnt_next;
            point_reg   <= point_next;
            start_reg   <= start_next;
            skip_reg    <= skip_next;
            m_valid_reg <= m_valid_next;
        end
        if (take_char && s_valid) begin
            char_reg <= s_char_code;
            eos_reg  <= s_end_of_string;
        end
        if (load_out) begin
            m_value_reg  <= out_value_c;
            m_status_reg <= out_status_c;
            m_last_reg   <= eos_reg;
        end
    end

    assign s_ready          = take_char;
    assign m_valid          = m_valid_reg;
    assign m_value          = m_value_reg;
    assign m_status         = m_status_reg;
    assign m_last_of_string = m_last_reg;

endmodule

// ----- design/dlfp_checker.sv -----
`include "assert_macros.svh"

module dlfp_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [dlfp_pkg::OUT_VALUE_W-1:0]    m_value,
    input logic [dlfp_pkg::STATUS_W-1:0]       m_status,
    input logic                                m_last_of_string
);
    import dlfp_pkg::*;

    logic [OUT_VALUE_W+STATUS_W:0] m_word;
    logic                          status_known;
    logic                          status_zero;

    assign m_word       = {m_value, m_status, m_last_of_string};
    assign status_known = m_status == STAT_OK || m_status == STAT_BAD_CHAR ||
                          m_status == STAT_MULTI_POINT || m_status == STAT_TRAIL_POINT ||
                          m_status == STAT_SATURATED;
    assign status_zero  = m_status == STAT_BAD_CHAR || m_status == STAT_MULTI_POINT ||
                          m_status == STAT_TRAIL_POINT;

    // Each character is decoded before the next one can be taken.
    `DLFP_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    `DLFP_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_word))

    `DLFP_ASSERT_IMPLY(a_status_known, aclk, aresetn, m_valid, status_known)

    // Parse errors always report a zero value.
    `DLFP_ASSERT_IMPLY(a_error_zero, aclk, aresetn, m_valid && status_zero, m_value == '0)

    `DLFP_ASSERT_NEXT_ALWAYS(a_reset_drops_result, aclk, !aresetn, !m_valid)

endmodule

bind decimal_list_to_fixed_point dlfp_checker u_dlfp_checker (.*);

// ----- tb/tb.sv -----
module tb;
    import dlfp_pkg::*;

    localparam int          LIMIT_CYCLES = 500000;
    localparam int          SETTLE       = 40;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          PHASE_CHARS  = 350;
    localparam bit [7:0]    SEP_NUL      = 8'h00;
    localparam bit [7:0]    SEP_ALL_ONES = 8'hFF;
    localparam bit [7:0]    SEP_SEMI     = 8'h3B;

    typedef struct {
        logic [OUT_VALUE_W-1:0] value;
        status_t                status;
        bit                     is_last;
    } parsed_t;

    // Tracks the parser state for every accepted character and keeps the
    // values that the block still owes, oldest first.
    class fixed_point_scoreboard;
        bit [7:0]          separator;
        bit                negative;
        longint unsigned   int_acc;
        longint unsigned   frac_acc;
        int unsigned       frac_digits;
        bit                point_seen;
        bit                field_start;
        bit                skipping;
        parsed_t           owed_q[$];
        int                errors;
        int                chars_seen;
        int                results_seen;
        int                status_hits[5];

        function new();
            separator = SEP_RESET;
            skipping  = 1'b0;
            clear_field();
        endfunction

        function void clear_field();
            negative    = 1'b0;
            int_acc     = 0;
            frac_acc    = 0;
            frac_digits = 0;
            point_seen  = 1'b0;
            field_start = 1'b1;
        endfunction

        function void set_separator(bit [7:0] sep);
            separator = sep;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void owe(logic [OUT_VALUE_W-1:0] v, status_t st, bit is_last);
            parsed_t r;
            r.value   = v;
            r.status  = st;
            r.is_last = is_last;
            owed_q = {owed_q, r};
        endfunction

        function void add_int_digit(longint unsigned d);
            longint unsigned t;
            if (int_acc > INT_LIMIT) return;
            if (int_acc > INT_LIMIT / 10) begin
                int_acc = INT_LIMIT + 1;
                return;
            end
            t = int_acc * 10;
            int_acc = (t + d > INT_LIMIT) ? INT_LIMIT + 1 : t + d;
        endfunction

        function status_t close_field(output logic [OUT_VALUE_W-1:0] v);
            longint unsigned top;
            longint unsigned max_mag;
            longint unsigned den;
            longint unsigned rem;
            longint unsigned q;
            longint unsigned mag;
            longint unsigned word;
            top = 64'd1 << (VALUE_BITS - 1);
            den = 1;
            q   = 0;
            v   = '0;
            if (point_seen && frac_digits == 0) return STAT_TRAIL_POINT;
            max_mag = negative ? top : top - 1;
            if (int_acc > INT_LIMIT) begin
                v = negative ? MOST_NEG : MOST_POS;
                return STAT_SATURATED;
            end
            for (int i = 0; i < frac_digits; i++) den = den * 10;
            rem = (frac_acc >= den) ? den - 1 : frac_acc;
            for (int i = 0; i < FRAC_BITS; i++) begin
                rem = rem << 1;
                q   = q << 1;
                if (rem >= den) begin
                    rem = rem - den;
                    q   = q | 1;
                end
            end
            if (2 * rem >= den && frac_digits != 0) q = q + 1;
            mag = (int_acc << FRAC_BITS) + q;
            if (mag > max_mag) begin
                v = negative ? MOST_NEG : MOST_POS;
                return STAT_SATURATED;
            end
            word = negative ? (64'd0 - mag) : mag;
            v = word[OUT_VALUE_W-1:0];
            return STAT_OK;
        endfunction

        function void note_char(bit [7:0] c, bit eos);
            logic [OUT_VALUE_W-1:0] v;
            status_t                st;
            status_t                err;
            chars_seen++;
            if (skipping) begin
                if (eos) begin
                    clear_field();
                    skipping = 1'b0;
                end
                return;
            end
            if (c == separator) begin
                st = close_field(v);
                owe(v, st, eos);
                clear_field();
                skipping = (st != STAT_OK) && !eos;
                return;
            end
            err = STAT_OK;
            if ((c == CHAR_PLUS || c == CHAR_MINUS) && field_start) begin
                negative = (c == CHAR_MINUS);
            end else if (c == CHAR_POINT) begin
                if (point_seen) err = STAT_MULTI_POINT;
                else point_seen = 1'b1;
            end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                if (point_seen) begin
                    if (frac_digits < MAX_FRAC_DIGITS) begin
                        frac_acc = frac_acc * 10 + (c - CHAR_ZERO);
                        frac_digits++;
                    end
                end else begin
                    add_int_digit(c - CHAR_ZERO);
                end
            end else begin
                err = STAT_BAD_CHAR;
            end
            field_start = 1'b0;
            if (err != STAT_OK) begin
                owe('0, err, eos);
                clear_field();
                skipping = !eos;
                return;
            end
            if (eos) begin
                st = close_field(v);
                owe(v, st, 1'b1);
                clear_field();
                skipping = 1'b0;
            end
        endfunction

        function void check_result(logic [OUT_VALUE_W-1:0] v, logic [STATUS_W-1:0] st,
                                   logic is_last);
            parsed_t want;
            results_seen++;
            if (owed_q.size() == 0) begin
                errors++;
                $error("result with no request pending: m_value %0h m_status %0d", v, st);
                return;
            end
            want = owed_q.pop_front();
            status_hits[int'(want.status)]++;
            if (v !== want.value) begin
                errors++;
                $error("m_value mismatch: expected %0d, actual %0d",
                       $signed(want.value), $signed(v));
            end
            if (st !== want.status) begin
                errors++;
                $error("m_status mismatch: expected %0d, actual %0d", want.status, st);
            end
            if (is_last !== want.is_last) begin
                errors++;
                $error("m_last_of_string mismatch: expected %0d, actual %0d",
                       want.is_last, is_last);
            end
        endfunction
    endclass

    logic                      aclk               = 1'b0;
    logic                      aresetn            = 1'b0;
    logic                      s_valid            = 1'b0;
    logic                      s_ready;
    logic [CHAR_W-1:0]         s_char_code        = '0;
    logic                      s_end_of_string    = 1'b0;
    logic                      m_valid;
    logic                      m_ready            = 1'b0;
    logic [OUT_VALUE_W-1:0]    m_value;
    logic [STATUS_W-1:0]       m_status;
    logic                      m_last_of_string;
    logic                      cfg_valid          = 1'b0;
    logic                      cfg_ready;
    logic [CHAR_W-1:0]         cfg_separator_char = SEP_RESET;

    fixed_point_scoreboard sb = new();
    int cycles    = 0;
    bit calm      = 1'b0;
    bit hold_go   = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    decimal_list_to_fixed_point i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_char_code        (s_char_code),
        .s_end_of_string    (s_end_of_string),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_value            (m_value),
        .m_status           (m_status),
        .m_last_of_string   (m_last_of_string),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_separator_char (cfg_separator_char)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The receiver takes results, with random stalls and one long hold-off.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_value, m_status, m_last_of_string);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 17);
            end
        end
    end

    task automatic send_char(bit [7:0] c, bit eos);
        while (!calm && $urandom_range(99) < 17) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_char_code     <= c;
        s_end_of_string <= eos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_char(c, eos);
    endtask

    task automatic send_text(string t);
        for (int i = 0; i < t.len(); i++) send_char(t[i], i == t.len() - 1);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() > 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_separator(bit [7:0] sep);
        drain();
        cfg_separator_char <= sep;
        cfg_valid          <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.set_separator(sep);
    endtask

    // Mostly well-formed lists with random content, some fields replaced by noise.
    task automatic send_random_list();
        bit [7:0] txt[$];
        int       n_fields;
        int       n_digits;
        n_fields = $urandom_range(1, 4);
        for (int f = 0; f < n_fields; f++) begin
            if (f > 0) txt = {txt, sb.separator};
            if ($urandom_range(99) < 82) begin
                case ($urandom_range(3))
                    0: txt = {txt, CHAR_MINUS};
                    1: txt = {txt, CHAR_PLUS};
                    default: ;
                endcase
                n_digits = ($urandom_range(9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 5);
                repeat (n_digits) txt = {txt, 8'(CHAR_ZERO + $urandom_range(9))};
                if ($urandom_range(9) < 7) begin
                    txt = {txt, CHAR_POINT};
                    n_digits = ($urandom_range(7) == 0) ? $urandom_range(7, 11)
                                                        : $urandom_range(0, 6);
                    repeat (n_digits) txt = {txt, 8'(CHAR_ZERO + $urandom_range(9))};
                end
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    case ($urandom_range(3))
                        0: txt = {txt, 8'($urandom_range(255))};
                        1: txt = {txt, CHAR_POINT};
                        2: txt = {txt, ($urandom_range(1) ? CHAR_PLUS : CHAR_MINUS)};
                        default: txt = {txt, 8'(CHAR_ZERO + $urandom_range(9))};
                    endcase
                end
            end
        end
        if (txt.size() == 0 || $urandom_range(9) == 0) txt = {txt, sb.separator};
        foreach (txt[i]) send_char(txt[i], i == txt.size() - 1);
    endtask

    task automatic run_lists(int n_chars);
        int target;
        target = sb.chars_seen + n_chars;
        while (sb.chars_seen < target) send_random_list();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_text("-.");
        send_text("+");
        send_text("7,");
        send_text("-32768");
        send_text("40000");
        send_text("1.2.3");
        send_text("1-");
        send_text(".5");
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);

        run_lists(PHASE_CHARS);
        write_separator(SEP_NUL);
        run_lists(PHASE_CHARS);
        write_separator(SEP_ALL_ONES);
        hold_go = 1'b1;
        run_lists(PHASE_CHARS);
        write_separator(SEP_SEMI);
        calm = 1'b1;
        run_lists(PHASE_CHARS);
        calm = 1'b0;
        write_separator(SEP_RESET);
        run_lists(PHASE_CHARS);

        drain();
        $display("Sent %0d characters over five separator phases; checked %0d values.",
                 sb.chars_seen, sb.results_seen);
        $display("Statuses: ok %0d, bad %0d, points %0d, trailing %0d, saturated %0d.",
                 sb.status_hits[0], sb.status_hits[1], sb.status_hits[2],
                 sb.status_hits[3], sb.status_hits[4]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
